### design/sst_pkg.sv
package sst_pkg;

  localparam int unsigned MAX_TOKENS  = 3;
  localparam int unsigned KW_COUNT    = 11;
  localparam int unsigned KW_MAX_CHARS = 6;

  localparam logic [5:0] T_EOF     = 6'd0;
  localparam logic [5:0] T_ERROR   = 6'd1;
  localparam logic [5:0] T_NUMBER  = 6'd2;
  localparam logic [5:0] T_STRING  = 6'd3;
  localparam logic [5:0] T_IDENT   = 6'd4;
  localparam logic [5:0] T_KW0     = 6'd5;
  localparam logic [5:0] T_OP0     = 6'd16;
  localparam logic [5:0] T_SLASH   = 6'd25;
  localparam logic [5:0] T_EQUAL   = 6'd27;
  localparam logic [5:0] T_BANG    = 6'd29;
  localparam logic [5:0] T_LESS    = 6'd31;
  localparam logic [5:0] T_GREATER = 6'd33;
  localparam logic [5:0] T_AND     = 6'd35;
  localparam logic [5:0] T_OR      = 6'd36;
  localparam logic [5:0] T_UNTERM  = 6'd37;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LESS   = 8'h3C;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_GREATER = 8'h3E;
  localparam logic [7:0] CH_BAR    = 8'h7C;

  localparam logic [KW_COUNT-1:0][KW_MAX_CHARS-1:0][7:0] KW_TEXT = '{
    {8'h00, 8'h74, 8'h6E, 8'h69, 8'h72, 8'h70},  // print
    {8'h00, 8'h00, 8'h00, 8'h6C, 8'h69, 8'h6E},  // nil
    {8'h00, 8'h65, 8'h73, 8'h6C, 8'h61, 8'h66},  // false
    {8'h00, 8'h00, 8'h65, 8'h75, 8'h72, 8'h74},  // true
    {8'h6E, 8'h72, 8'h75, 8'h74, 8'h65, 8'h72},  // return
    {8'h00, 8'h00, 8'h00, 8'h00, 8'h6E, 8'h66},  // fn
    {8'h00, 8'h00, 8'h00, 8'h72, 8'h6F, 8'h66},  // for
    {8'h00, 8'h65, 8'h6C, 8'h69, 8'h68, 8'h77},  // while
    {8'h00, 8'h00, 8'h65, 8'h73, 8'h6C, 8'h65},  // else
    {8'h00, 8'h00, 8'h00, 8'h00, 8'h66, 8'h69},  // if
    {8'h00, 8'h00, 8'h00, 8'h74, 8'h65, 8'h6C}   // let
  };

  localparam logic [KW_COUNT-1:0][2:0] KW_LEN = '{
    3'd5, 3'd3, 3'd5, 3'd4, 3'd6, 3'd2, 3'd3, 3'd5, 3'd4, 3'd2, 3'd3
  };

  typedef struct packed {
    logic       req_type;
    logic [7:0] char_byte;
  } req_t;

  typedef struct packed {
    logic [5:0]  token_type;
    logic [15:0] start_offset;
    logic [15:0] token_length;
    logic [15:0] line_number;
    logic        last_of_run;
  } result_t;

  typedef struct packed {
    logic [5:0]  token_type;
    logic [15:0] start_offset;
    logic [15:0] token_length;
    logic [15:0] line_number;
  } tok_t;

  typedef struct packed {
    tok_t [MAX_TOKENS-1:0] tok;
    logic [1:0]            count;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           (c == 8'h5F);
  endfunction

  function automatic logic [5:0] single_op(input logic [7:0] c);
    logic [5:0] t;
    unique case (c)
      8'h28:   t = T_OP0;
      8'h29:   t = T_OP0 + 6'd1;
      8'h7B:   t = T_OP0 + 6'd2;
      8'h7D:   t = T_OP0 + 6'd3;
      8'h3B:   t = T_OP0 + 6'd4;
      8'h2C:   t = T_OP0 + 6'd5;
      8'h2B:   t = T_OP0 + 6'd6;
      8'h2D:   t = T_OP0 + 6'd7;
      8'h2A:   t = T_OP0 + 6'd8;
      CH_SLASH: t = T_SLASH;
      8'h25:   t = T_OP0 + 6'd10;
      default: t = T_ERROR;
    endcase
    return t;
  endfunction

  function automatic logic [5:0] op_first(input logic [7:0] p);
    logic [5:0] t;
    unique case (p)
      CH_EQUAL:   t = T_EQUAL;
      CH_BANG:    t = T_BANG;
      CH_LESS:    t = T_LESS;
      CH_GREATER: t = T_GREATER;
      default:    t = T_ERROR;
    endcase
    return t;
  endfunction

endpackage

### design/sst_front.sv
module sst_front import sst_pkg::*; #(
  parameter int unsigned OFFSET_BITS   = 16,
  parameter int unsigned KEYWORD_CHARS = 6
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      accept,
  input  req_t      req,
  output logic      push,
  output bundle_t   bundle
);

  localparam int unsigned EXT_W = (OFFSET_BITS > 16) ? OFFSET_BITS : 16;
  localparam int unsigned WL_W  = $clog2(KEYWORD_CHARS + 2);

  typedef enum logic [8:0] {
    M_IDLE     = 9'b000000001,
    M_COMMENT  = 9'b000000010,
    M_NUM      = 9'b000000100,
    M_NUM_DOT  = 9'b000001000,
    M_NUM_FRAC = 9'b000010000,
    M_IDENT    = 9'b000100000,
    M_STR      = 9'b001000000,
    M_SLASH    = 9'b010000000,
    M_OP       = 9'b100000000
  } mode_t;

  mode_t                             mode, mode_next;
  logic [OFFSET_BITS-1:0]            position, position_next;
  logic [OFFSET_BITS-1:0]            token_start, token_start_next;
  logic [15:0]                       line_count, line_count_next;
  logic [7:0]                        pending, pending_next;
  logic [KEYWORD_CHARS-1:0][7:0]     wbuf, wbuf_next;
  logic [WL_W-1:0]                   wlen, wlen_next;

  logic [OFFSET_BITS-1:0] pos_inc, dot_pos, len_cur, len_dot;
  logic [5:0]             word_kind;
  logic                   line_inc, do_flush, do_start, match;
  logic [1:0]             ntok;
  logic [7:0]             c;

  function automatic logic [15:0] to16(input logic [OFFSET_BITS-1:0] v);
    logic [EXT_W-1:0] w;
    w = EXT_W'(v);
    return w[15:0];
  endfunction

  function automatic logic [OFFSET_BITS-1:0] sub0(input logic [OFFSET_BITS-1:0] a,
                                                  input logic [OFFSET_BITS-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  assign c       = req.char_byte;
  assign pos_inc = (position == {OFFSET_BITS{1'b1}}) ? position : position + 1'b1;
  assign dot_pos = sub0(position, {{(OFFSET_BITS-1){1'b0}}, 1'b1});
  assign len_cur = sub0(position, token_start);
  assign len_dot = sub0(dot_pos, token_start);

  always_comb begin
    word_kind = T_IDENT;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      match = (wlen == WL_W'(KW_LEN[k]));
      for (int i = 0; i < KEYWORD_CHARS; i++) begin
        if (i < KW_MAX_CHARS) begin
          match = match && (wbuf[i] == KW_TEXT[k][i]);
        end else begin
          match = match && (wbuf[i] == 8'h00);
        end
      end
      if (match) begin
        word_kind = T_KW0 + 6'(k);
      end
    end
  end

  always_comb begin
    mode_next        = mode;
    token_start_next = token_start;
    pending_next     = pending;
    wbuf_next        = wbuf;
    wlen_next        = wlen;
    position_next    = pos_inc;
    line_inc         = 1'b0;
    do_flush         = 1'b0;
    do_start         = 1'b0;
    ntok             = 2'd0;
    bundle           = '0;

    if (req.req_type) begin
      do_flush = 1'b1;
    end else begin
      unique case (mode)
        M_IDLE: begin
          do_start = 1'b1;
        end
        M_COMMENT: begin
          if (c == CH_NL) begin
            line_inc  = 1'b1;
            mode_next = M_IDLE;
          end
        end
        M_NUM: begin
          if (c == CH_DOT) begin
            mode_next = M_NUM_DOT;
          end else if (!is_digit(c)) begin
            do_flush = 1'b1;
            do_start = 1'b1;
          end
        end
        M_NUM_DOT: begin
          if (is_digit(c)) begin
            mode_next = M_NUM_FRAC;
          end else begin
            do_flush = 1'b1;
            do_start = 1'b1;
          end
        end
        M_NUM_FRAC: begin
          if (!is_digit(c)) begin
            do_flush = 1'b1;
            do_start = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_alpha(c) || is_digit(c)) begin
            for (int i = 0; i < KEYWORD_CHARS; i++) begin
              if (wlen == WL_W'(i)) begin
                wbuf_next[i] = c;
              end
            end
            if (wlen <= WL_W'(KEYWORD_CHARS)) begin
              wlen_next = wlen + 1'b1;
            end
          end else begin
            do_flush = 1'b1;
            do_start = 1'b1;
          end
        end
        M_STR: begin
          if (c == CH_QUOTE) begin
            bundle.tok[ntok] = '{T_STRING, to16(token_start),
                                 to16(sub0(position, token_start)), line_count};
            ntok      = ntok + 2'd1;
            mode_next = M_IDLE;
          end else if (c == CH_NL) begin
            line_inc = 1'b1;
          end
        end
        M_SLASH: begin
          if (c == CH_SLASH) begin
            mode_next = M_COMMENT;
          end else begin
            do_flush = 1'b1;
            do_start = 1'b1;
          end
        end
        M_OP: begin
          if (c == CH_EQUAL && op_first(pending) != T_ERROR) begin
            bundle.tok[ntok] = '{op_first(pending) + 6'd1, to16(token_start), 16'd2,
                                 line_count};
            ntok      = ntok + 2'd1;
            mode_next = M_IDLE;
          end else if (c == CH_AMP && pending == CH_AMP) begin
            bundle.tok[ntok] = '{T_AND, to16(token_start), 16'd2, line_count};
            ntok      = ntok + 2'd1;
            mode_next = M_IDLE;
          end else if (c == CH_BAR && pending == CH_BAR) begin
            bundle.tok[ntok] = '{T_OR, to16(token_start), 16'd2, line_count};
            ntok      = ntok + 2'd1;
            mode_next = M_IDLE;
          end else begin
            do_flush = 1'b1;
            do_start = 1'b1;
          end
        end
        default: begin
          do_start = 1'b1;
        end
      endcase
    end

    if (do_flush) begin
      mode_next = M_IDLE;
      unique case (mode)
        M_NUM, M_NUM_FRAC: begin
          bundle.tok[ntok] = '{T_NUMBER, to16(token_start), to16(len_cur), line_count};
          ntok = ntok + 2'd1;
        end
        M_NUM_DOT: begin
          bundle.tok[ntok] = '{T_NUMBER, to16(token_start), to16(len_dot), line_count};
          ntok = ntok + 2'd1;
          bundle.tok[ntok] = '{T_ERROR, to16(dot_pos), 16'd1, line_count};
          ntok = ntok + 2'd1;
        end
        M_IDENT: begin
          bundle.tok[ntok] = '{word_kind, to16(token_start), to16(len_cur), line_count};
          ntok = ntok + 2'd1;
        end
        M_STR: begin
          bundle.tok[ntok] = '{T_UNTERM, to16(token_start), 16'd0, line_count};
          ntok = ntok + 2'd1;
        end
        M_SLASH: begin
          bundle.tok[ntok] = '{T_SLASH, to16(token_start), 16'd1, line_count};
          ntok = ntok + 2'd1;
        end
        M_OP: begin
          bundle.tok[ntok] = '{op_first(pending), to16(token_start), 16'd1, line_count};
          ntok = ntok + 2'd1;
        end
        default: begin
        end
      endcase
    end

    if (do_start) begin
      mode_next = M_IDLE;
      if (c == CH_SPACE || c == CH_CR || c == CH_TAB) begin
        mode_next = M_IDLE;
      end else if (c == CH_NL) begin
        line_inc = 1'b1;
      end else begin
        token_start_next = position;
        if (is_digit(c)) begin
          mode_next = M_NUM;
        end else if (is_alpha(c)) begin
          mode_next    = M_IDENT;
          wbuf_next    = '0;
          wbuf_next[0] = c;
          wlen_next    = WL_W'(1);
        end else if (c == CH_QUOTE) begin
          mode_next        = M_STR;
          token_start_next = pos_inc;
        end else if (c == CH_SLASH) begin
          mode_next = M_SLASH;
        end else if (op_first(c) != T_ERROR || c == CH_AMP || c == CH_BAR) begin
          mode_next    = M_OP;
          pending_next = c;
        end else begin
          bundle.tok[ntok] = '{single_op(c), to16(position), 16'd1, line_count};
          ntok = ntok + 2'd1;
        end
      end
    end

    line_count_next = (line_inc && line_count != 16'hFFFF) ? line_count + 16'd1 : line_count;

    if (req.req_type) begin
      bundle.tok[ntok] = '{T_EOF, to16(position), 16'd0, line_count};
      ntok             = ntok + 2'd1;
      mode_next        = M_IDLE;
      position_next    = '0;
      token_start_next = '0;
      line_count_next  = 16'd1;
      pending_next     = 8'h00;
      wbuf_next        = '0;
      wlen_next        = '0;
    end

    bundle.count = ntok;
  end

  assign push = accept && (ntok != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= M_IDLE;
      position    <= '0;
      token_start <= '0;
      line_count  <= 16'd1;
      pending     <= 8'h00;
      wbuf        <= '0;
      wlen        <= '0;
    end else if (accept) begin
      mode        <= mode_next;
      position    <= position_next;
      token_start <= token_start_next;
      line_count  <= line_count_next;
      pending     <= pending_next;
      wbuf        <= wbuf_next;
      wlen        <= wlen_next;
    end
  end

endmodule

### design/sst_queue.sv
module sst_queue import sst_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  bundle_t   wdata,
  input  logic      pop,
  output bundle_t   head,
  output q_status_t status
);

  bundle_t    slots [2];
  logic       wptr, rptr;
  logic [1:0] fill;

  assign head         = slots[rptr];
  assign status.full  = (fill == 2'd2);
  assign status.empty = (fill == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### design/sst_back.sv
module sst_back import sst_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  bundle_t   head,
  input  q_status_t status,
  output logic      pop,
  output logic      tok_valid,
  input  logic      tok_stall,
  output result_t   tok
);

  logic [1:0] idx;
  logic       load, take, last;
  tok_t       cur;

  assign load = !tok_valid || !tok_stall;
  assign take = load && !status.empty;
  assign cur  = head.tok[idx];
  assign last = (idx == head.count - 2'd1);
  assign pop  = take && last;

  always_ff @(posedge clk) begin
    if (take) begin
      tok <= '{cur.token_type, cur.start_offset, cur.token_length, cur.line_number, last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      tok_valid <= take;
      if (take) begin
        idx <= last ? 2'd0 : idx + 2'd1;
      end
    end
  end

endmodule

### design/script_source_tokenizer.sv
// Streaming source scanner. Each transaction on the req channel carries one source byte or
// the end-of-source marker, and the tok channel returns the tokens it completes, one
// transaction per token, with last_of_run set on the final token of each input. The front
// end classifies a byte per cycle while the queue has room, and passes the finished tokens
// of each input as a group through a two-entry queue to the back end, which sends one
// token per cycle from its output register while tok_stall is low. Inputs that complete at
// most one token therefore flow at one byte per cycle; an input that completes two or
// three sends them in turn and the queue absorbs that until it fills. After the end marker
// all scan state returns to its reset values so a new source can follow immediately.
module script_source_tokenizer import sst_pkg::*; #(
  parameter int unsigned OFFSET_BITS   = 16,
  parameter int unsigned KEYWORD_CHARS = 6
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_stall,
  input  req_t    req,
  output logic    tok_valid,
  input  logic    tok_stall,
  output result_t tok
);

  logic      accept, q_push, q_pop;
  bundle_t   q_wdata, q_head;
  q_status_t q_stat;

  assign req_stall = q_stat.full;
  assign accept    = req_valid && !req_stall;

  sst_front #(
    .OFFSET_BITS  (OFFSET_BITS),
    .KEYWORD_CHARS(KEYWORD_CHARS)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .accept(accept),
    .req   (req),
    .push  (q_push),
    .bundle(q_wdata)
  );

  sst_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .head  (q_head),
    .status(q_stat)
  );

  sst_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (q_head),
    .status   (q_stat),
    .pop      (q_pop),
    .tok_valid(tok_valid),
    .tok_stall(tok_stall),
    .tok      (tok)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("token queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("token queue read while empty");

  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    (tok_valid && tok.token_type == T_EOF) |-> tok.last_of_run)
    else $error("end-of-file token not marked as last of its run");

  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    tok_valid |-> (tok.line_number != 16'd0))
    else $error("token carries line number zero");

endmodule

### dv/script_source_tokenizer_tb.sv
`timescale 1ns / 100ps

import sst_pkg::*;

class token_checker;
  typedef enum logic [3:0] {
    SC_IDLE, SC_COMMENT, SC_NUM, SC_NUM_DOT, SC_NUM_FRAC, SC_IDENT, SC_STR, SC_SLASH, SC_OP
  } scan_e;

  string keywords[11] = '{"let", "if", "else", "while", "for", "fn", "return", "true",
                          "false", "nil", "print"};
  string single_ops = "(){};,+-*/%";

  result_t     expected_tokens[$];
  result_t     run[$];
  logic [15:0] pos;
  logic [15:0] tok_start;
  logic [15:0] line_cnt;
  scan_e       mode;
  logic [7:0]  held_op;
  logic [7:0]  word [6];
  int unsigned word_len;
  int          errors;

  function new();
    errors = 0;
    clear_state();
  endfunction

  function void clear_state();
    pos = '0;
    tok_start = '0;
    line_cnt = 16'd1;
    mode = SC_IDLE;
    held_op = '0;
    word_len = 0;
    foreach (word[i]) word[i] = '0;
  endfunction

  function int pending();
    return expected_tokens.size();
  endfunction

  function logic num_char(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function logic word_char(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function logic [15:0] sat_next(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function logic [15:0] diff(logic [15:0] a, logic [15:0] b);
    return (a > b) ? a - b : 16'd0;
  endfunction

  function void bump_line();
    if (line_cnt != 16'hFFFF) line_cnt++;
  endfunction

  function void put(logic [5:0] code, logic [15:0] at, logic [15:0] len);
    result_t t;
    t.token_type = code;
    t.start_offset = at;
    t.token_length = len;
    t.line_number = line_cnt;
    t.last_of_run = 1'b0;
    run = {run, t};
  endfunction

  function void add_char(logic [7:0] c);
    if (word_len < 6) word[word_len] = c;
    if (word_len <= 6) word_len++;
  endfunction

  function logic [5:0] word_code();
    logic match;
    for (int k = 0; k < 11; k++) begin
      if (word_len == keywords[k].len()) begin
        match = 1'b1;
        for (int i = 0; i < keywords[k].len(); i++)
          if (word[i] != keywords[k].getc(i)) match = 1'b0;
        if (match) return T_KW0 + 6'(k);
      end
    end
    return T_IDENT;
  endfunction

  function logic [5:0] op_code(logic [7:0] p);
    case (p)
      CH_EQUAL: return T_EQUAL;
      CH_BANG: return T_BANG;
      CH_LESS: return T_LESS;
      CH_GREATER: return T_GREATER;
      default: return T_ERROR;
    endcase
  endfunction

  function void start_char(logic [7:0] c, logic [15:0] at);
    logic [5:0] code;
    mode = SC_IDLE;
    if (c == CH_SPACE || c == CH_CR || c == CH_TAB) return;
    if (c == CH_NL) begin
      bump_line();
      return;
    end
    tok_start = at;
    if (num_char(c)) begin
      mode = SC_NUM;
    end else if (word_char(c)) begin
      mode = SC_IDENT;
      word_len = 0;
      add_char(c);
    end else if (c == CH_QUOTE) begin
      mode = SC_STR;
      tok_start = sat_next(at);
    end else if (c == CH_SLASH) begin
      mode = SC_SLASH;
    end else if (c == CH_EQUAL || c == CH_BANG || c == CH_LESS || c == CH_GREATER ||
                 c == CH_AMP || c == CH_BAR) begin
      mode = SC_OP;
      held_op = c;
    end else begin
      code = T_ERROR;
      for (int k = 0; k < single_ops.len(); k++)
        if (single_ops.getc(k) == c) code = T_OP0 + 6'(k);
      put(code, at, 16'd1);
    end
  endfunction

  function void flush();
    logic [15:0] dot;
    case (mode)
      SC_NUM, SC_NUM_FRAC: put(T_NUMBER, tok_start, diff(pos, tok_start));
      SC_NUM_DOT: begin
        dot = diff(pos, 16'd1);
        put(T_NUMBER, tok_start, diff(dot, tok_start));
        put(T_ERROR, dot, 16'd1);
      end
      SC_IDENT: put(word_code(), tok_start, diff(pos, tok_start));
      SC_STR: put(T_UNTERM, tok_start, 16'd0);
      SC_SLASH: put(T_SLASH, tok_start, 16'd1);
      SC_OP: put(op_code(held_op), tok_start, 16'd1);
      default: ;
    endcase
    mode = SC_IDLE;
  endfunction

  function void rescan(logic [7:0] c);
    flush();
    start_char(c, pos);
  endfunction

  function void note_request(req_t r);
    logic [7:0] c;
    c = r.char_byte;
    run.delete();
    if (r.req_type) begin
      flush();
      put(T_EOF, pos, 16'd0);
      clear_state();
    end else begin
      case (mode)
        SC_COMMENT: begin
          if (c == CH_NL) begin
            bump_line();
            mode = SC_IDLE;
          end
        end
        SC_NUM: begin
          if (c == CH_DOT) mode = SC_NUM_DOT;
          else if (!num_char(c)) rescan(c);
        end
        SC_NUM_DOT: begin
          if (num_char(c)) mode = SC_NUM_FRAC;
          else rescan(c);
        end
        SC_NUM_FRAC: if (!num_char(c)) rescan(c);
        SC_IDENT: begin
          if (word_char(c) || num_char(c)) add_char(c);
          else rescan(c);
        end
        SC_STR: begin
          if (c == CH_QUOTE) begin
            put(T_STRING, tok_start, diff(pos, tok_start));
            mode = SC_IDLE;
          end else if (c == CH_NL) begin
            bump_line();
          end
        end
        SC_SLASH: begin
          if (c == CH_SLASH) mode = SC_COMMENT;
          else rescan(c);
        end
        SC_OP: begin
          if (c == CH_EQUAL && (held_op == CH_EQUAL || held_op == CH_BANG ||
                                held_op == CH_LESS || held_op == CH_GREATER)) begin
            put(op_code(held_op) + 6'd1, tok_start, 16'd2);
            mode = SC_IDLE;
          end else if (c == CH_AMP && held_op == CH_AMP) begin
            put(T_AND, tok_start, 16'd2);
            mode = SC_IDLE;
          end else if (c == CH_BAR && held_op == CH_BAR) begin
            put(T_OR, tok_start, 16'd2);
            mode = SC_IDLE;
          end else begin
            rescan(c);
          end
        end
        default: start_char(c, pos);
      endcase
      pos = sat_next(pos);
    end
    if (run.size() > 0) run[run.size() - 1].last_of_run = 1'b1;
    expected_tokens = {expected_tokens, run};
  endfunction

  function void compare_field(string field, logic [15:0] want, logic [15:0] got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  function void check_token(result_t got);
    result_t want;
    if (expected_tokens.size() == 0) begin
      errors++;
      $display("%0t: unexpected token, expected none, actual type %0d start %0d length %0d",
               $time, got.token_type, got.start_offset, got.token_length);
      return;
    end
    want = expected_tokens.pop_front();
    compare_field("token_type", 16'(want.token_type), 16'(got.token_type));
    compare_field("start_offset", want.start_offset, got.start_offset);
    compare_field("token_length", want.token_length, got.token_length);
    compare_field("line_number", want.line_number, got.line_number);
    compare_field("last_of_run", 16'(want.last_of_run), 16'(got.last_of_run));
  endfunction
endclass

module script_source_tokenizer_tb;
  import sst_pkg::*;

  localparam int LONG_HOLD_CYCLES = 200;

  logic    clk = 1'b0;
  logic    rst;
  logic    req_valid;
  logic    req_stall;
  req_t    req;
  logic    tok_valid;
  logic    tok_stall;
  result_t tok;

  token_checker sb;
  logic [7:0]   text[$];
  int           burst_left = 0;
  int           gap_max = 3;
  int           sent;
  bit           long_hold_req = 1'b0;

  string op_words[23] = '{"(", ")", "{", "}", ";", ",", "+", "-", "*", "/", "%", "=", "==",
                          "!", "!=", "<", "<=", ">", ">=", "&&", "||", "&", "|"};

  script_source_tokenizer i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall),
    .tok       (tok)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && req_valid && !req_stall) sb.note_request(req);
    if (!rst && tok_valid && !tok_stall) sb.check_token(tok);
  end

  task automatic send_req(input logic end_mark, input logic [7:0] b);
    req_t r;
    r.req_type = end_mark;
    r.char_byte = b;
    if (gap_max > 0 && burst_left == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk);
      burst_left = $urandom_range(1, 10);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic send_source();
    foreach (text[i]) send_req(1'b0, text[i]);
    send_req(1'b1, 8'($urandom_range(0, 255)));
    sent += text.size() + 1;
    text.delete();
  endtask

  task automatic wait_for_tokens();
    req_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic void add_byte(logic [7:0] b);
    text = {text, b};
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s.getc(i));
  endfunction

  function automatic logic [7:0] pick_letter();
    int k;
    k = $urandom_range(0, 52);
    if (k < 26) return 8'("a" + k);
    if (k < 52) return 8'("A" + k - 26);
    return "_";
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] pick_printable();
    logic [7:0] c;
    c = 8'($urandom_range(32, 126));
    return (c == CH_QUOTE) ? "q" : c;
  endfunction

  function automatic void add_lexeme();
    int kind;
    int shape;
    kind = $urandom_range(0, 10);
    case (kind)
      0: add_text(sb.keywords[$urandom_range(0, 10)]);
      1: begin
        add_byte(pick_letter());
        repeat ($urandom_range(0, 8))
          add_byte(($urandom_range(0, 3) == 0) ? pick_digit() : pick_letter());
      end
      2: begin
        add_text(sb.keywords[$urandom_range(0, 10)]);
        add_byte(pick_letter());
      end
      3: begin
        repeat ($urandom_range(1, 4)) add_byte(pick_digit());
        shape = $urandom_range(0, 3);
        if (shape == 1) begin
          add_byte(CH_DOT);
          repeat ($urandom_range(1, 3)) add_byte(pick_digit());
        end else if (shape == 2) begin
          add_byte(CH_DOT);
        end
      end
      4: begin
        add_byte(CH_QUOTE);
        repeat ($urandom_range(0, 8))
          add_byte(($urandom_range(0, 9) == 0) ? CH_NL : pick_printable());
        if ($urandom_range(0, 9) != 0) add_byte(CH_QUOTE);
      end
      5, 6, 7: add_text(op_words[$urandom_range(0, 22)]);
      8: begin
        add_text("//");
        repeat ($urandom_range(0, 6)) add_byte(pick_printable());
        if ($urandom_range(0, 4) != 0) add_byte(CH_NL);
      end
      9: begin
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(0, 3))
            0: add_byte(CH_SPACE);
            1: add_byte(CH_TAB);
            2: add_byte(CH_CR);
            default: add_byte(CH_NL);
          endcase
        end
      end
      default: add_byte(8'($urandom_range(0, 255)));
    endcase
    if ($urandom_range(0, 1) == 0) add_byte(CH_SPACE);
  endfunction

  initial begin
    int span;
    int mode_sel;
    int cnt;
    span = 0;
    mode_sel = 0;
    cnt = 0;
    tok_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        tok_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        tok_stall <= 1'b0;
      end else begin
        if (span == 0) begin
          span = $urandom_range(5, 60);
          mode_sel = $urandom_range(0, 3);
        end
        span--;
        cnt++;
        case (mode_sel)
          0: tok_stall <= 1'b0;
          1: tok_stall <= ($urandom_range(0, 3) == 0);
          2: tok_stall <= ($urandom_range(0, 3) != 0);
          default: tok_stall <= ((cnt % 4) < 2);
        endcase
      end
    end
  end

  initial begin
    sb = new();
    sent = 0;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed sources: operator pairs, number then dot, byte extremes, lone & and |,
    // an unterminated string, a comment, and a slash flushed by the end marker.
    add_text("x<=1.)");
    add_byte(8'h00);
    add_byte(8'hFF);
    add_text("& |\"a");
    send_source();
    add_text("//c\n!=/");
    foreach (text[i]) send_req(1'b0, text[i]);
    text.delete();
    send_req(1'b1, 8'hA5);
    wait_for_tokens();

    while (sent < 140) begin
      repeat ($urandom_range(2, 14)) add_lexeme();
      case ($urandom_range(0, 2))
        0: gap_max = 0;
        1: gap_max = 2;
        default: gap_max = 6;
      endcase
      send_source();
      if ($urandom_range(0, 3) == 0) wait_for_tokens();
    end

    wait_for_tokens();
    gap_max = 0;
    long_hold_req = 1'b1;
    repeat (12) add_text("1.(");
    repeat (20) add_text("(");
    send_source();
    wait_for_tokens();

    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end
endmodule
